// ===== sv/bta_pkg.sv =====
// bta_pkg: microcode program, control word and field widths of the bakery ticket arbiter
`timescale 1ns / 1ps
`default_nettype none

package bta_pkg;

    // fixed widths of the transaction fields
    localparam int REQ_W    = 4;
    localparam int TICKET_W = 8;
    localparam int GID_W    = 4;

    // microprogram step addresses
    typedef enum logic [1:0] {
        ST_WAIT  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_DRAIN = 2'd2,
        ST_FINAL = 2'd3
    } t_step;

    // jump conditions; when the condition holds the sequencer goes to jmp, else to step + 1
    typedef enum logic [1:0] {
        COND_NEVER    = 2'd0,
        COND_NO_ITEM  = 2'd1,
        COND_MORE     = 2'd2,
        COND_OUT_BUSY = 2'd3
    } t_cond;

    typedef struct packed {
        logic  in_rdy;  // offer o_ready, latch item and clear accumulators on accept
        logic  rd_en;   // read table entry at scan index, advance index
        logic  acc_en;  // fold the entry read last cycle into max and min
        logic  fin_en;  // write back the requester entry and load the result
        t_cond cond;
        t_step jmp;
    } t_uword;

    function automatic t_uword uc_rom(input t_step step);
        t_uword w;
        w = '0;
        unique case (step)
            ST_WAIT: begin
                w.in_rdy = 1'b1;
                w.cond   = COND_NO_ITEM;
                w.jmp    = ST_WAIT;
            end
            ST_SCAN: begin
                w.rd_en  = 1'b1;
                w.acc_en = 1'b1;
                w.cond   = COND_MORE;
                w.jmp    = ST_SCAN;
            end
            ST_DRAIN: begin
                w.acc_en = 1'b1;
                w.cond   = COND_NEVER;
                w.jmp    = ST_WAIT;
            end
            ST_FINAL: begin
                // step + 1 wraps back to the wait step
                w.fin_en = 1'b1;
                w.cond   = COND_OUT_BUSY;
                w.jmp    = ST_FINAL;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== sv/bta_table.sv =====
// bta_table: ticket memory with per-entry valid bits and a registered read port
`timescale 1ns / 1ps
`default_nettype none

module bta_table #(
    parameter int NUM_REQUESTERS = 16,
    parameter int TICKET_BITS    = 8,
    parameter int ID_W           = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_rd_en,
    input  wire logic [ID_W-1:0]        i_rd_addr,
    output logic      [TICKET_BITS-1:0] o_rd_data,
    input  wire logic                   i_wr_en,
    input  wire logic [ID_W-1:0]        i_wr_addr,
    input  wire logic [TICKET_BITS-1:0] i_wr_data
);

    logic [TICKET_BITS-1:0]    r_mem [NUM_REQUESTERS];
    logic [NUM_REQUESTERS-1:0] r_valid;
    logic [TICKET_BITS-1:0]    r_rdata;
    logic                      r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    // an entry never written since reset reads as no ticket
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rvld  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rvld <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rvld ? r_rdata : '0;

endmodule

`default_nettype wire

// ===== sv/bakery_ticket_arbiter_core.sv =====
// bakery_ticket_arbiter_core: bakery-style ticket arbiter run by a small microprogram
//
// input channel (i_valid / o_ready) carries one command per transaction: i_cmd 0 takes a
// ticket for i_requester, 1 releases it. each command gives exactly one result transaction
// on the output channel (o_valid / i_ready): the ticket the requester now holds, an
// overflow flag for a refused take, and the current lock holder (lowest nonzero ticket,
// lower index on a tie).
// after the accepting edge the sequencer scans the table entry by entry (the single table
// read port sets this), then drains the read pipeline, then writes back and loads the result
// register, and only then returns to the wait step for the next command.
// the scan finds the largest ticket and the lowest ticket of all other requesters in one
// pass; the requester's own new ticket is merged at the end.
// o_ready is high only in the wait step, so a new command is taken as soon as the previous
// one has loaded its result, even while that result still waits in the output register.
// a stalled receiver holds the sequencer in its final step until the register frees up.
// reset clears all tickets (per-entry valid bits), the sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module bakery_ticket_arbiter_core #(
    parameter int NUM_REQUESTERS = 16,
    parameter int TICKET_BITS    = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_cmd,
    input  wire logic [bta_pkg::REQ_W-1:0]     i_requester,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic      [bta_pkg::TICKET_W-1:0]  o_issued_ticket,
    output logic                               o_status,
    output logic                               o_grant_valid,
    output logic      [bta_pkg::GID_W-1:0]     o_grant_id,
    output logic      [bta_pkg::TICKET_W-1:0]  o_grant_ticket
);

    localparam int ID_W = $clog2(NUM_REQUESTERS);
    localparam int TB   = TICKET_BITS;
    localparam int RW   = bta_pkg::REQ_W;
    localparam logic [ID_W-1:0] LAST_IDX = ID_W'(NUM_REQUESTERS - 1);

    // sequencer
    bta_pkg::t_step  r_step, n_step;
    bta_pkg::t_uword uw;
    logic            in_acc;
    logic            out_busy;
    logic            cond_true;
    logic            fin_fire;
    logic            acc_fire;

    // item and scan datapath
    logic            r_cmd;
    logic [ID_W-1:0] r_who;
    logic            r_inrange;
    logic [ID_W-1:0] r_idx;
    logic [ID_W-1:0] r_pidx;
    logic            r_pend;
    logic [TB-1:0]   r_top;
    logic [TB-1:0]   r_old;
    logic            r_gv;
    logic [ID_W-1:0] r_gid;
    logic [TB-1:0]   r_gt;
    logic [TB-1:0]   entry;
    logic [ID_W+RW-1:0] who_ext;

    // final merge
    logic            ovf;
    logic [TB-1:0]   v_who;
    logic            who_wins;
    logic            f_gv;
    logic [ID_W-1:0] f_gid;
    logic [TB-1:0]   f_gt;
    logic [TB+bta_pkg::TICKET_W-1:0]  issued_ext;
    logic [TB+bta_pkg::TICKET_W-1:0]  gt_ext;
    logic [ID_W+bta_pkg::GID_W-1:0]   gid_ext;

    // output register
    logic                         r_out_valid;
    logic [bta_pkg::TICKET_W-1:0] r_issued;
    logic                         r_status;
    logic                         r_ogv;
    logic [bta_pkg::GID_W-1:0]    r_ogid;
    logic [bta_pkg::TICKET_W-1:0] r_ogt;

    assign uw       = bta_pkg::uc_rom(r_step);
    assign o_ready  = uw.in_rdy;
    assign in_acc   = uw.in_rdy & i_valid;
    assign out_busy = r_out_valid & ~i_ready;
    assign fin_fire = uw.fin_en & ~out_busy;
    assign acc_fire = uw.acc_en & r_pend;

    always_comb begin
        unique case (uw.cond)
            bta_pkg::COND_NEVER:    cond_true = 1'b0;
            bta_pkg::COND_NO_ITEM:  cond_true = ~i_valid;
            bta_pkg::COND_MORE:     cond_true = (r_idx != LAST_IDX);
            bta_pkg::COND_OUT_BUSY: cond_true = out_busy;
        endcase
        n_step = cond_true ? uw.jmp : bta_pkg::t_step'(r_step + 2'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= bta_pkg::ST_WAIT;
            r_pend <= 1'b0;
        end else begin
            r_step <= n_step;
            r_pend <= uw.rd_en;
        end
    end

    bta_table #(
        .NUM_REQUESTERS (NUM_REQUESTERS),
        .TICKET_BITS    (TICKET_BITS),
        .ID_W           (ID_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (uw.rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (entry),
        .i_wr_en   (fin_fire & r_inrange),
        .i_wr_addr (r_who),
        .i_wr_data (v_who)
    );

    assign who_ext = {{ID_W{1'b0}}, i_requester};

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd     <= i_cmd;
            r_who     <= who_ext[ID_W-1:0];
            r_inrange <= who_ext < (ID_W+RW)'(NUM_REQUESTERS);
            r_idx     <= '0;
            r_top     <= '0;
            r_old     <= '0;
            r_gv      <= 1'b0;
            r_gid     <= '0;
            r_gt      <= '0;
        end else begin
            if (uw.rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
            r_pidx <= r_idx;
            if (acc_fire) begin
                if (entry > r_top) begin
                    r_top <= entry;
                end
                // the requester's own entry is kept aside, the rest compete for the grant
                if (r_inrange && r_pidx == r_who) begin
                    r_old <= entry;
                end else if (entry != '0 && (!r_gv || entry < r_gt)) begin
                    r_gv  <= 1'b1;
                    r_gid <= r_pidx;
                    r_gt  <= entry;
                end
            end
        end
    end

    // new ticket of the requester and the merge with the best of the others
    always_comb begin
        ovf = r_inrange & ~r_cmd & (&r_top);
        priority if (!r_inrange || r_cmd) begin
            v_who = '0;
        end else if (ovf) begin
            v_who = r_old;
        end else begin
            v_who = r_top + 1'b1;
        end
        who_wins = r_inrange && v_who != '0 &&
                   (!r_gv || v_who < r_gt || (v_who == r_gt && r_who < r_gid));
        f_gv  = who_wins | r_gv;
        f_gid = who_wins ? r_who : r_gid;
        f_gt  = who_wins ? v_who : r_gt;
        issued_ext = {{bta_pkg::TICKET_W{1'b0}}, v_who};
        gt_ext     = {{bta_pkg::TICKET_W{1'b0}}, f_gt};
        gid_ext    = {{bta_pkg::GID_W{1'b0}}, f_gid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (fin_fire) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_fire) begin
            r_issued <= issued_ext[bta_pkg::TICKET_W-1:0];
            r_status <= ovf;
            r_ogv    <= f_gv;
            r_ogid   <= gid_ext[bta_pkg::GID_W-1:0];
            r_ogt    <= gt_ext[bta_pkg::TICKET_W-1:0];
        end
    end

    assign o_valid         = r_out_valid;
    assign o_issued_ticket = r_issued;
    assign o_status        = r_status;
    assign o_grant_valid   = r_ogv;
    assign o_grant_id      = r_ogid;
    assign o_grant_ticket  = r_ogt;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for the bakery ticket arbiter core
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_REQ     = 16;
    localparam int ITEM_CYCLES = NUM_REQ + 3;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;

    typedef enum bit {
        CMD_TAKE    = 1'b0,
        CMD_RELEASE = 1'b1
    } t_lock_cmd;

    typedef enum bit {
        STATUS_OK       = 1'b0,
        STATUS_OVERFLOW = 1'b1
    } t_lock_status;

    typedef struct packed {
        logic [bta_pkg::TICKET_W-1:0] issued_ticket;
        logic                         status;
        logic                         grant_valid;
        logic [bta_pkg::GID_W-1:0]    grant_id;
        logic [bta_pkg::TICKET_W-1:0] grant_ticket;
    } t_lock_result;

    // ticket table mirror and the queue of lock results still owed by the block
    class ticket_scoreboard;
        bit [bta_pkg::TICKET_W-1:0] held_ticket [NUM_REQ];
        t_lock_result               owed_results [$];
        int                         mismatch_count;
        int                         result_count;

        task report_mismatch(string msg);
            mismatch_count++;
            $display("tb_top: mismatch at result %0d: %s", result_count, msg);
        endtask

        function int pending_count();
            return owed_results.size();
        endfunction

        // one atomic bakery step on the mirror, result queued for comparison
        function void note_command(t_lock_cmd cmd, logic [bta_pkg::REQ_W-1:0] who);
            t_lock_result               r;
            bit [bta_pkg::TICKET_W-1:0] top;
            r   = '0;
            top = '0;
            foreach (held_ticket[i])
                if (held_ticket[i] > top)
                    top = held_ticket[i];
            if (int'(who) < NUM_REQ) begin
                if (cmd == CMD_TAKE) begin
                    if (top == {bta_pkg::TICKET_W{1'b1}})
                        r.status = STATUS_OVERFLOW;
                    else
                        held_ticket[who] = top + 1'b1;
                end else begin
                    held_ticket[who] = '0;
                end
                r.issued_ticket = held_ticket[who];
            end
            // strict less-than keeps the lower index on a tie
            foreach (held_ticket[i]) begin
                if (held_ticket[i] != 0 &&
                    (!r.grant_valid || held_ticket[i] < r.grant_ticket)) begin
                    r.grant_valid  = 1'b1;
                    r.grant_id     = bta_pkg::GID_W'(i);
                    r.grant_ticket = held_ticket[i];
                end
            end
            owed_results.push_back(r);
        endfunction

        task check_result(t_lock_result got);
            t_lock_result want;
            result_count++;
            if (owed_results.size() == 0) begin
                report_mismatch("result with no command outstanding");
                return;
            end
            want = owed_results.pop_front();
            if (got.issued_ticket !== want.issued_ticket)
                report_mismatch($sformatf("issued_ticket %0h, want %0h",
                                          got.issued_ticket, want.issued_ticket));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0h, want %0h", got.status, want.status));
            if (got.grant_valid !== want.grant_valid)
                report_mismatch($sformatf("grant_valid %0h, want %0h",
                                          got.grant_valid, want.grant_valid));
            if (got.grant_id !== want.grant_id)
                report_mismatch($sformatf("grant_id %0h, want %0h", got.grant_id, want.grant_id));
            if (got.grant_ticket !== want.grant_ticket)
                report_mismatch($sformatf("grant_ticket %0h, want %0h",
                                          got.grant_ticket, want.grant_ticket));
        endtask

        task flush_leftovers();
            while (owed_results.size() != 0) begin
                void'(owed_results.pop_front());
                report_mismatch("command never produced a result");
            end
        endtask
    endclass

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_valid     = 1'b0;
    logic                         i_cmd       = 1'b0;
    logic [bta_pkg::REQ_W-1:0]    i_requester = '0;
    logic                         i_ready     = 1'b0;
    logic                         o_ready;
    logic                         o_valid;
    logic [bta_pkg::TICKET_W-1:0] o_issued_ticket;
    logic                         o_status;
    logic                         o_grant_valid;
    logic [bta_pkg::GID_W-1:0]    o_grant_id;
    logic [bta_pkg::TICKET_W-1:0] o_grant_ticket;

    ticket_scoreboard sb = new();

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit rx_hold_req  = 1'b0;
    int cycle_count  = 0;

    bakery_ticket_arbiter_core #(
        .NUM_REQUESTERS (NUM_REQ),
        .TICKET_BITS    (bta_pkg::TICKET_W)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_requester     (i_requester),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_issued_ticket (o_issued_ticket),
        .o_status        (o_status),
        .o_grant_valid   (o_grant_valid),
        .o_grant_id      (o_grant_id),
        .o_grant_ticket  (o_grant_ticket)
    );

    always #6 i_clk = ~i_clk;

    // handshakes sampled mid-cycle, where every signal is settled
    always @(negedge i_clk) begin
        t_lock_result got;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_command(t_lock_cmd'(i_cmd), i_requester);
            if (o_valid && i_ready) begin
                got.issued_ticket = o_issued_ticket;
                got.status        = o_status;
                got.grant_valid   = o_grant_valid;
                got.grant_id      = o_grant_id;
                got.grant_ticket  = o_grant_ticket;
                sb.check_result(got);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                i_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge i_clk) cycle_count++;
        $display("tb_top: FAIL");
        $finish;
    end

    // called just after a rising edge, returns just after the edge that took the transaction
    task automatic send_command(input t_lock_cmd cmd, input logic [bta_pkg::REQ_W-1:0] who);
        bit accepted;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_requester <= who;
        do begin
            @(negedge i_clk);
            accepted = i_valid && o_ready;
            @(posedge i_clk);
        end while (!accepted);
    endtask

    task automatic pause_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_count() != 0);
    endtask

    // climbs run the tickets up into overflow, drains empty the table, mixed in between
    task automatic run_episodes(input int n_items, input bit with_hold);
        int        sent;
        int        len;
        int        take_pct;
        int        kind;
        t_lock_cmd c;
        sent = 0;
        if (with_hold)
            rx_hold_req = 1'b1;
        while (sent < n_items) begin
            kind = (sent == 0) ? 0 : $urandom_range(9);
            if (kind < 3) begin
                len      = $urandom_range(320, 280);
                take_pct = 95;
            end else if (kind < 6) begin
                len      = $urandom_range(60, 20);
                take_pct = 15;
            end else begin
                len      = $urandom_range(100, 30);
                take_pct = 50;
            end
            if (len > n_items - sent)
                len = n_items - sent;
            repeat (len) begin
                c = ($urandom_range(99) < take_pct) ? CMD_TAKE : CMD_RELEASE;
                send_command(c, bta_pkg::REQ_W'($urandom_range(NUM_REQ - 1)));
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct  = 17;
        rx_stall_pct = 60;

        // directed: first take, re-take by a holder, releases with and without a ticket
        send_command(CMD_RELEASE, 4'd0);
        send_command(CMD_TAKE,    4'd0);
        send_command(CMD_TAKE,    4'd15);
        send_command(CMD_TAKE,    4'd0);
        send_command(CMD_RELEASE, 4'd15);
        send_command(CMD_RELEASE, 4'd7);
        send_command(CMD_RELEASE, 4'd0);
        send_command(CMD_RELEASE, 4'd0);
        send_command(CMD_TAKE,    4'd8);
        send_command(CMD_TAKE,    4'd5);
        send_command(CMD_TAKE,    4'd10);
        send_command(CMD_TAKE,    4'd3);
        send_command(CMD_RELEASE, 4'd5);
        send_command(CMD_RELEASE, 4'd8);
        send_command(CMD_TAKE,    4'd8);
        send_command(CMD_RELEASE, 4'd10);
        send_command(CMD_RELEASE, 4'd3);
        send_command(CMD_RELEASE, 4'd8);
        pause_until_drained();

        run_episodes(600, 1'b1);
        pause_until_drained();

        tx_idle_pct  = 60;
        rx_stall_pct = 17;
        run_episodes(600, 1'b0);
        pause_until_drained();

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        run_episodes(600, 1'b1);

        pause_until_drained();
        repeat (2 * ITEM_CYCLES) @(posedge i_clk);
        sb.flush_leftovers();

        if (sb.mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bta_pkg.sv
sv/bta_table.sv
sv/bakery_ticket_arbiter_core.sv
verif/tb_top.sv
